@@ rtl/vff_pkg.sv @@
// Shared types, command encoding and datapath widths for the viscous face flux block.
package vff_pkg;

    localparam int IN_W   = 32;   // field width of every Q value
    localparam int W_W    = 17;   // interpolation weight width
    localparam int E_W    = 36;   // 3*dev(T) element width
    localparam int MA_W   = 37;   // multiplier operand A
    localparam int MB_W   = 34;   // multiplier operand B
    localparam int ACC_W  = 71;   // product and dot-product accumulator
    localparam int MAG_W  = 68;   // magnitude of the dot product
    localparam int CH_W   = 34;   // chunk of the magnitude per partial product
    localparam int WIDE_W = 101;  // full magnitude times viscosity, plus rounding carry
    localparam int DIG_W  = 16;   // digit width of the divide-by-three stepper
    localparam int DIV_SH = 20;
    localparam logic [18:0] DIV_M = 19'd349525;  // floor(2^20 / 3)

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IMUL,
        ST_IRND,
        ST_EDEV,
        ST_DOT,
        ST_MAG,
        ST_MMUL,
        ST_RADD,
        ST_DIV,
        ST_SAT,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_IMUL,
        OP_IRND,
        OP_EDEV,
        OP_DOT,
        OP_MAG,
        OP_MMUL,
        OP_RADD,
        OP_DIV,
        OP_SAT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] cnt;   // column, term, chunk or digit index
        logic [1:0] comp;  // flux component
        logic [1:0] row;   // tensor row being interpolated
    } cmd_t;

endpackage

@@ rtl/vff_ctrl.sv @@
// Sequencer for the viscous face flux: walks each item through the shared datapath.
module vff_ctrl #(
    parameter int NUM_DIG = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output vff_pkg::cmd_t cmd
);

    vff_pkg::state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;
    logic [1:0] row_count_reg, row_count_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] last_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vff_pkg::ST_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            row_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            row_count_reg <= row_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // third row also interpolates the viscosity
    assign last_col = (row_count_reg == 2'd2) ? 3'd3 : 3'd2;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        row_count_next = row_count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd.op         = vff_pkg::OP_NONE;
        cmd.cnt        = cnt_reg;
        cmd.comp       = comp_reg;
        cmd.row        = row_count_reg;
        unique case (state_reg)
            vff_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = vff_pkg::OP_LOAD;
                    cnt_next   = '0;
                    state_next = vff_pkg::ST_IMUL;
                end
            end
            vff_pkg::ST_IMUL: begin
                cmd.op     = vff_pkg::OP_IMUL;
                state_next = vff_pkg::ST_IRND;
            end
            vff_pkg::ST_IRND: begin
                cmd.op = vff_pkg::OP_IRND;
                if (cnt_reg == last_col) begin
                    cnt_next = '0;
                    if (row_count_reg == 2'd2) begin
                        row_count_next = '0;
                        state_next     = vff_pkg::ST_EDEV;
                    end else begin
                        row_count_next = row_count_reg + 2'd1;
                        state_next     = vff_pkg::ST_IDLE;
                    end
                end else begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = vff_pkg::ST_IMUL;
                end
            end
            vff_pkg::ST_EDEV: begin
                cmd.op     = vff_pkg::OP_EDEV;
                cnt_next   = '0;
                comp_next  = '0;
                state_next = vff_pkg::ST_DOT;
            end
            vff_pkg::ST_DOT: begin
                cmd.op = vff_pkg::OP_DOT;
                if (cnt_reg == 3'd2) begin
                    cnt_next   = '0;
                    state_next = vff_pkg::ST_MAG;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            vff_pkg::ST_MAG: begin
                cmd.op     = vff_pkg::OP_MAG;
                cnt_next   = '0;
                state_next = vff_pkg::ST_MMUL;
            end
            vff_pkg::ST_MMUL: begin
                cmd.op = vff_pkg::OP_MMUL;
                if (cnt_reg == 3'd1) begin
                    cnt_next   = '0;
                    state_next = vff_pkg::ST_RADD;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            vff_pkg::ST_RADD: begin
                cmd.op     = vff_pkg::OP_RADD;
                cnt_next   = '0;
                state_next = vff_pkg::ST_DIV;
            end
            vff_pkg::ST_DIV: begin
                cmd.op = vff_pkg::OP_DIV;
                if (cnt_reg == 3'(NUM_DIG - 1)) begin
                    cnt_next   = '0;
                    state_next = vff_pkg::ST_SAT;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            vff_pkg::ST_SAT: begin
                cmd.op   = vff_pkg::OP_SAT;
                cnt_next = '0;
                if (comp_reg == 2'd2) begin
                    state_next = vff_pkg::ST_EMIT;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = vff_pkg::ST_DOT;
                end
            end
            vff_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = vff_pkg::OP_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = vff_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vff_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == vff_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ rtl/vff_dp.sv @@
// Datapath: shared multiplier, accumulator, divide-by-three stepper and result registers.
module vff_dp #(
    parameter int FRAC_BITS = 16,
    parameter int SAT_W     = 32,
    parameter int NUM_DIG   = 5
) (
    input  logic                              aclk,
    input  vff_pkg::cmd_t                     cmd,
    input  logic        [vff_pkg::W_W-1:0]    s_weight,
    input  logic signed [vff_pkg::IN_W-1:0]   s_visc_own,
    input  logic signed [vff_pkg::IN_W-1:0]   s_visc_nbr,
    input  logic signed [vff_pkg::IN_W-1:0]   s_area_x,
    input  logic signed [vff_pkg::IN_W-1:0]   s_area_y,
    input  logic signed [vff_pkg::IN_W-1:0]   s_area_z,
    input  logic signed [vff_pkg::IN_W-1:0]   s_own_row_c0,
    input  logic signed [vff_pkg::IN_W-1:0]   s_own_row_c1,
    input  logic signed [vff_pkg::IN_W-1:0]   s_own_row_c2,
    input  logic signed [vff_pkg::IN_W-1:0]   s_nbr_row_c0,
    input  logic signed [vff_pkg::IN_W-1:0]   s_nbr_row_c1,
    input  logic signed [vff_pkg::IN_W-1:0]   s_nbr_row_c2,
    output logic signed [vff_pkg::IN_W-1:0]   m_flux_x,
    output logic signed [vff_pkg::IN_W-1:0]   m_flux_y,
    output logic signed [vff_pkg::IN_W-1:0]   m_flux_z,
    output logic                              m_saturated
);

    localparam int IN_W   = vff_pkg::IN_W;
    localparam int W_W    = vff_pkg::W_W;
    localparam int E_W    = vff_pkg::E_W;
    localparam int MA_W   = vff_pkg::MA_W;
    localparam int MB_W   = vff_pkg::MB_W;
    localparam int ACC_W  = vff_pkg::ACC_W;
    localparam int MAG_W  = vff_pkg::MAG_W;
    localparam int CH_W   = vff_pkg::CH_W;
    localparam int WIDE_W = vff_pkg::WIDE_W;
    localparam int DIG_W  = vff_pkg::DIG_W;
    localparam int QW     = NUM_DIG * DIG_W;
    localparam logic [IN_W-1:0]   ONE      = IN_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0]  RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [WIDE_W-1:0] RND_FLUX = WIDE_W'(3) << (2 * FRAC_BITS - 1);
    localparam logic [QW-1:0]     LIM_NEG  = QW'(1) << (SAT_W - 1);
    localparam logic [QW-1:0]     LIM_POS  = LIM_NEG - QW'(1);

    // latched item
    logic        [W_W-1:0]  weight_reg;
    logic signed [IN_W-1:0] visc_own_reg, visc_nbr_reg;
    logic signed [IN_W-1:0] own_reg [3];
    logic signed [IN_W-1:0] nbr_reg [3];
    logic signed [IN_W-1:0] area_reg [3];

    // interpolated tensor, row major, and viscosity
    logic signed [IN_W-1:0] g_reg [9];
    logic signed [IN_W-1:0] mu_reg;
    logic signed [E_W-1:0]  e_reg [9];

    logic signed [ACC_W-1:0]  acc_reg;
    logic        [MAG_W-1:0]  mag_reg;
    logic                     neg_reg;
    logic        [WIDE_W-1:0] wide_reg;
    logic        [QW-1:0]     dvd_reg;
    logic        [1:0]        rem_reg;
    logic signed [IN_W-1:0]   res_reg [3];
    logic                     sat_reg;

    logic        [W_W-1:0]    wq;
    logic signed [IN_W-1:0]   sel_a, sel_b;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  prod;
    logic                     acc_neg;
    logic        [ACC_W-1:0]  acc_mag, rnd_mag, rnd_res;
    logic        [3:0]        g_idx, e_idx;
    logic        [IN_W-1:0]   mu_mag;
    logic        [CH_W-1:0]   chunk;
    logic        [WIDE_W-1:0] wide_rnd;
    logic        [17:0]       cur, three_est, rem_est;
    logic        [36:0]       est_full;
    logic        [16:0]       est, quo;
    logic                     fix;
    logic        [QW-1:0]     lim, qv, qsigned;
    logic                     over;
    logic signed [33:0]       tr;
    logic signed [E_W-1:0]    e_calc [9];
    logic signed [E_W-1:0]    pair;

    assign wq = ({{(IN_W - W_W){1'b0}}, weight_reg} > ONE) ? ONE[W_W-1:0] : weight_reg;

    always_comb begin
        if (cmd.cnt == 3'd3) begin
            sel_a = visc_own_reg;
            sel_b = visc_nbr_reg;
        end else begin
            sel_a = own_reg[cmd.cnt[1:0]];
            sel_b = nbr_reg[cmd.cnt[1:0]];
        end
    end

    assign e_idx  = 4'(cmd.comp) * 4'd3 + 4'(cmd.cnt[1:0]);
    assign g_idx  = 4'(cmd.row) * 4'd3 + 4'(cmd.cnt[1:0]);
    assign mu_mag = mu_reg[IN_W-1] ? IN_W'(-mu_reg) : IN_W'(mu_reg);
    assign chunk  = cmd.cnt[0] ? mag_reg[MAG_W-1:CH_W] : mag_reg[CH_W-1:0];

    // one shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            vff_pkg::OP_IMUL: begin
                mul_a = {{(MA_W - W_W){1'b0}}, wq};
                mul_b = MB_W'(sel_a) - MB_W'(sel_b);
            end
            vff_pkg::OP_DOT: begin
                mul_a = MA_W'(e_reg[e_idx]);
                mul_b = MB_W'(area_reg[cmd.cnt[1:0]]);
            end
            vff_pkg::OP_MMUL: begin
                mul_a = {{(MA_W - CH_W){1'b0}}, chunk};
                mul_b = {{(MB_W - IN_W){1'b0}}, mu_mag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // round half away from zero
    assign acc_neg = acc_reg[ACC_W-1];
    assign acc_mag = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign rnd_mag = (acc_mag + RND_HALF) >> FRAC_BITS;
    assign rnd_res = acc_neg ? (~rnd_mag + ACC_W'(1)) : rnd_mag;

    // 3*dev(T): diagonal 6g - 2tr, off diagonal 3(g_ij + g_ji)
    assign tr = 34'(g_reg[0]) + 34'(g_reg[4]) + 34'(g_reg[8]);
    always_comb begin
        pair = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i == j) begin
                    pair = E_W'(g_reg[i * 3 + j]);
                    e_calc[i * 3 + j] = (pair <<< 2) + (pair <<< 1) - (E_W'(tr) <<< 1);
                end else begin
                    pair = E_W'(g_reg[i * 3 + j]) + E_W'(g_reg[j * 3 + i]);
                    e_calc[i * 3 + j] = (pair <<< 1) + pair;
                end
            end
        end
    end

    assign wide_rnd = (wide_reg + RND_FLUX) >> (2 * FRAC_BITS);

    // one 16-bit digit of the divide by three, reciprocal estimate plus one correction
    assign cur       = {rem_reg, dvd_reg[QW-1 -: DIG_W]};
    assign est_full  = 37'(cur) * 37'(vff_pkg::DIV_M);
    assign est       = est_full[36:vff_pkg::DIV_SH];
    assign three_est = {est, 1'b0} + 18'(est);
    assign rem_est   = cur - three_est;
    assign fix       = (rem_est >= 18'd3);
    assign quo       = fix ? (est + 17'd1) : est;

    assign lim     = neg_reg ? LIM_NEG : LIM_POS;
    assign over    = (dvd_reg > lim);
    assign qv      = over ? lim : dvd_reg;
    assign qsigned = neg_reg ? (~qv + QW'(1)) : qv;

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            vff_pkg::OP_LOAD: begin
                weight_reg   <= s_weight;
                visc_own_reg <= s_visc_own;
                visc_nbr_reg <= s_visc_nbr;
                area_reg[0]  <= s_area_x;
                area_reg[1]  <= s_area_y;
                area_reg[2]  <= s_area_z;
                own_reg[0]   <= s_own_row_c0;
                own_reg[1]   <= s_own_row_c1;
                own_reg[2]   <= s_own_row_c2;
                nbr_reg[0]   <= s_nbr_row_c0;
                nbr_reg[1]   <= s_nbr_row_c1;
                nbr_reg[2]   <= s_nbr_row_c2;
            end
            vff_pkg::OP_IMUL: begin
                acc_reg <= prod + (ACC_W'(sel_b) <<< FRAC_BITS);
            end
            vff_pkg::OP_IRND: begin
                if (cmd.cnt == 3'd3) begin
                    mu_reg <= rnd_res[IN_W-1:0];
                end else begin
                    g_reg[g_idx] <= rnd_res[IN_W-1:0];
                end
            end
            vff_pkg::OP_EDEV: begin
                e_reg   <= e_calc;
                sat_reg <= 1'b0;
            end
            vff_pkg::OP_DOT: begin
                acc_reg <= ((cmd.cnt == 3'd0) ? ACC_W'(0) : acc_reg) + prod;
            end
            vff_pkg::OP_MAG: begin
                mag_reg <= acc_mag[MAG_W-1:0];
                neg_reg <= acc_neg ^ mu_reg[IN_W-1];
            end
            vff_pkg::OP_MMUL: begin
                if (cmd.cnt[0]) begin
                    wide_reg <= wide_reg + (WIDE_W'(prod[2*CH_W-3:0]) << CH_W);
                end else begin
                    wide_reg <= WIDE_W'(prod[2*CH_W-3:0]);
                end
            end
            vff_pkg::OP_RADD: begin
                dvd_reg <= wide_rnd[QW-1:0];
                rem_reg <= '0;
            end
            vff_pkg::OP_DIV: begin
                dvd_reg <= {dvd_reg[QW-DIG_W-1:0], quo[DIG_W-1:0]};
                rem_reg <= fix ? 2'(rem_est - 18'd3) : rem_est[1:0];
            end
            vff_pkg::OP_SAT: begin
                res_reg[cmd.comp] <= qsigned[IN_W-1:0];
                sat_reg           <= sat_reg | over;
            end
            vff_pkg::OP_EMIT: begin
                m_flux_x    <= res_reg[0];
                m_flux_y    <= res_reg[1];
                m_flux_z    <= res_reg[2];
                m_saturated <= sat_reg;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/viscous_face_flux.sv @@
// Top level of the viscous face flux block: sequencer, datapath and checks.
//
// A face is sent as three row transfers; each carries one row of the owner and
// neighbour gradient tensors plus the weight, both viscosities and the area
// vector. Rows are interpolated as w*own + (1-w)*nbr (w clamped to 1.0) and
// rounded half away from zero. The first two rows are only stored; on the
// third the block forms mu_f from that transfer's operands and emits one flux
// transfer mu_f*(T - tr(T)/3 I).S with T = G + G^T, rounded half away from zero
// and saturated to min(DATA_WIDTH,32) signed bits, sign-extended to 32; the
// saturated flag marks any clipped component.
// All arithmetic goes through one shared 37x34 multiplier and a 16-bit-per-step
// divide-by-three unit, one item at a time. A stored row is interpolated column
// by column; the closing row then forms 3*dev(T) and, per component, a dot
// product, magnitude multiply, rounding, ND = ceil((101 - 2*FRAC_BITS)/16)
// divide digits and saturation, plus any wait for the previous result to be
// taken. The result register lets the next face start while a flux waits.
module viscous_face_flux #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic        [16:0] s_weight,
    input  logic signed [31:0] s_visc_own,
    input  logic signed [31:0] s_visc_nbr,
    input  logic signed [31:0] s_area_x,
    input  logic signed [31:0] s_area_y,
    input  logic signed [31:0] s_area_z,
    input  logic signed [31:0] s_own_row_c0,
    input  logic signed [31:0] s_own_row_c1,
    input  logic signed [31:0] s_own_row_c2,
    input  logic signed [31:0] s_nbr_row_c0,
    input  logic signed [31:0] s_nbr_row_c1,
    input  logic signed [31:0] s_nbr_row_c2,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_flux_x,
    output logic signed [31:0] m_flux_y,
    output logic signed [31:0] m_flux_z,
    output logic               m_saturated
);

    // saturation width and digit count of the divide-by-three pass
    localparam int SAT_W   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int NUM_DIG =
        (vff_pkg::WIDE_W - 2 * FRAC_BITS + vff_pkg::DIG_W - 1) / vff_pkg::DIG_W;
    localparam logic [31:0] SAT_MAX = 32'((33'd1 << (SAT_W - 1)) - 33'd1);
    localparam logic [31:0] SAT_MIN = ~SAT_MAX;

    vff_pkg::cmd_t cmd;

    // control: state, row count of the current face, result valid
    vff_ctrl #(
        .NUM_DIG (NUM_DIG)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // arithmetic and the result register
    vff_dp #(
        .FRAC_BITS (FRAC_BITS),
        .SAT_W     (SAT_W),
        .NUM_DIG   (NUM_DIG)
    ) u_dp (
        .aclk         (aclk),
        .cmd          (cmd),
        .s_weight     (s_weight),
        .s_visc_own   (s_visc_own),
        .s_visc_nbr   (s_visc_nbr),
        .s_area_x     (s_area_x),
        .s_area_y     (s_area_y),
        .s_area_z     (s_area_z),
        .s_own_row_c0 (s_own_row_c0),
        .s_own_row_c1 (s_own_row_c1),
        .s_own_row_c2 (s_own_row_c2),
        .s_nbr_row_c0 (s_nbr_row_c0),
        .s_nbr_row_c1 (s_nbr_row_c1),
        .s_nbr_row_c2 (s_nbr_row_c2),
        .m_flux_x     (m_flux_x),
        .m_flux_y     (m_flux_y),
        .m_flux_z     (m_flux_z),
        .m_saturated  (m_saturated)
    );

`ifndef SYNTHESIS
    // a new result only appears right after the emit command loaded it
    a_emit_before_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.op == vff_pkg::OP_EMIT))
        else $error("result valid rose without an emit");

    // one item at a time: busy after every input transfer
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again while an item is in work");

    // a clipped result carries at least one component at a range limit
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_flux_x == SAT_MAX || m_flux_x == SAT_MIN ||
             m_flux_y == SAT_MAX || m_flux_y == SAT_MIN ||
             m_flux_z == SAT_MAX || m_flux_z == SAT_MIN))
        else $error("saturated flag without a clipped component");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the viscous face flux block: directed faces, then random faces.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_ITEMS   = 1050;      // three rows per face, whole faces only
    localparam int  QUIET_AT  = N_ITEMS - 150;
    localparam int  HOLD_AT   = 400;       // receiver holds off here for a long stretch
    localparam int  PAUSE_AT  = 700;       // sender drains the block here
    localparam int  WD_LIMIT  = 20000;
    localparam longint ONE    = 64'sd65536;

    typedef struct {
        logic        [16:0] w;
        logic signed [31:0] vo, vn, ax, ay, az;
        logic signed [31:0] own [3];
        logic signed [31:0] nbr [3];
    } face_row_t;

    typedef struct {
        logic signed [31:0] fx, fy, fz;
        logic               sat;
    } flux_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic        [16:0] s_weight = '0;
    logic signed [31:0] s_visc_own = '0, s_visc_nbr = '0;
    logic signed [31:0] s_area_x = '0, s_area_y = '0, s_area_z = '0;
    logic signed [31:0] s_own_row_c0 = '0, s_own_row_c1 = '0, s_own_row_c2 = '0;
    logic signed [31:0] s_nbr_row_c0 = '0, s_nbr_row_c1 = '0, s_nbr_row_c2 = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_flux_x, m_flux_y, m_flux_z;
    logic               m_saturated;

    viscous_face_flux dut (.*);

    // clock, 8 ns period
    initial begin
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Face flux predictor: own copy of the row store
    // ---------------------------------------------------------------
    int     rows_held = 0;
    longint held_rows [2][3];
    flux_t  flux_q [$];       // fluxes still to come out of the block

    int errors = 0;
    int n_sent = 0;
    int n_faces = 0;
    int n_clipped = 0;
    bit stim_done = 1'b0;
    bit quiet = 1'b0;         // final stretch with no idling on either side

    // rounded Q.16 interpolation, weight clamped to 1.0
    function automatic longint lerp_q16(logic [16:0] w, longint a, longint b);
        longint wq, v, m;
        wq = (longint'(w) > ONE) ? ONE : longint'(w);
        v  = wq * a + (ONE - wq) * b;
        m  = ((v < 0 ? -v : v) + 64'sd32768) >>> 16;
        return v < 0 ? -m : m;
    endfunction

    // one component: round(e.S * mu / (3 << 32)), half away from zero, then clipped
    function automatic logic signed [31:0] flux_component(longint e [3], longint s [3],
                                                         longint mu, inout logic clip);
        logic signed [127:0] acc, ea, sa;
        logic        [127:0] mag, mmu, lim;
        bit                  neg;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            ea = e[i];
            sa = s[i];
            acc += ea * sa;
        end
        neg = acc < 0;
        mag = neg ? -acc : acc;
        mmu = (mu < 0) ? -mu : mu;
        mag = mag * mmu;
        if (mu < 0) neg = !neg;
        mag = (mag + (128'd3 << 31)) >> 32;
        mag = mag / 3;
        lim = neg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
        if (mag > lim) begin
            clip = 1'b1;
            mag  = lim;
        end
        return neg ? -mag[31:0] : mag[31:0];
    endfunction

    // feed one accepted row; returns 1 with the flux when it closes a face
    function automatic bit face_predict(face_row_t r, output flux_t f);
        longint g [3][3];
        longint e [3];
        longint s [3];
        longint row [3];
        longint mu, tr;
        logic   clip;
        for (int j = 0; j < 3; j++) row[j] = lerp_q16(r.w, r.own[j], r.nbr[j]);
        if (rows_held < 2) begin
            for (int j = 0; j < 3; j++) held_rows[rows_held][j] = row[j];
            rows_held++;
            return 1'b0;
        end
        rows_held = 0;
        for (int j = 0; j < 3; j++) begin
            g[0][j] = held_rows[0][j];
            g[1][j] = held_rows[1][j];
            g[2][j] = row[j];
        end
        mu   = lerp_q16(r.w, r.vo, r.vn);
        s[0] = r.ax;
        s[1] = r.ay;
        s[2] = r.az;
        tr   = g[0][0] + g[1][1] + g[2][2];
        clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                e[j] = (i == j) ? 6 * g[i][i] - 2 * tr : 3 * (g[i][j] + g[j][i]);
            case (i)
                0: f.fx = flux_component(e, s, mu, clip);
                1: f.fy = flux_component(e, s, mu, clip);
                default: f.fz = flux_component(e, s, mu, clip);
            endcase
        end
        f.sat = clip;
        return 1'b1;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("MISMATCH %s: expected %h got %h (face %0d)", what, want, got, n_faces);
    endtask

    // ---------------------------------------------------------------
    // Directed faces: a table of rows; typed fluxes where obvious
    // ---------------------------------------------------------------
    localparam int N_DIR = 18;
    face_row_t dir_rows [N_DIR];
    bit        dir_has_flux [N_DIR];
    flux_t     dir_flux [N_DIR];

    function automatic face_row_t mk_row(logic [16:0] w, logic [31:0] vo, logic [31:0] vn,
                                         logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                         logic [31:0] o0, logic [31:0] o1, logic [31:0] o2,
                                         logic [31:0] n0, logic [31:0] n1, logic [31:0] n2);
        face_row_t r;
        r.w = w; r.vo = vo; r.vn = vn; r.ax = ax; r.ay = ay; r.az = az;
        r.own[0] = o0; r.own[1] = o1; r.own[2] = o2;
        r.nbr[0] = n0; r.nbr[1] = n1; r.nbr[2] = n2;
        return r;
    endfunction

    initial begin
        localparam logic [31:0] MX = 32'h7fffffff;
        localparam logic [31:0] MN = 32'h80000000;
        localparam logic [16:0] W1 = 17'd65536;
        dir_has_flux = '{default: 1'b0};
        // all-zero face straight after reset: zero flux
        dir_rows[0]  = mk_row(17'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[1]  = mk_row(17'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[2]  = mk_row(17'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_has_flux[2] = 1'b1;
        dir_flux[2]  = '{fx: 0, fy: 0, fz: 0, sat: 1'b0};
        // pure shear at full scale, boundary face (w = 1): x clips high
        dir_rows[3]  = mk_row(W1, 5, 7, 9, 9, 9, 0, MX, 0, MN, MN, MN);
        dir_rows[4]  = mk_row(W1, 5, 7, 9, 9, 9, MX, 0, 0, MN, MN, MN);
        dir_rows[5]  = mk_row(W1, MX, MN, 0, MX, 0, 0, 0, 0, MN, MN, MN);
        dir_has_flux[5] = 1'b1;
        dir_flux[5]  = '{fx: MX, fy: 0, fz: 0, sat: 1'b1};
        // same shear, area pointing the other way: x clips low
        dir_rows[6]  = mk_row(W1, 0, 0, 0, 0, 0, 0, MX, 0, 0, 0, 0);
        dir_rows[7]  = mk_row(W1, 0, 0, 0, 0, 0, MX, 0, 0, 0, 0, 0);
        dir_rows[8]  = mk_row(W1, MX, 0, 0, MN, 0, 0, 0, 0, 0, 0, 0);
        dir_has_flux[8] = 1'b1;
        dir_flux[8]  = '{fx: MN, fy: 0, fz: 0, sat: 1'b1};
        // weight above one is clamped
        dir_rows[9]  = mk_row(17'h1ffff, 1, 2, 3, 4, 5, 32'h00012345, 32'hfff00000,
                              32'h00030000, MX, MN, MX);
        dir_rows[10] = mk_row(17'h10001, 1, 2, 3, 4, 5, 32'h00008000, 32'h00001000,
                              32'hfffe0000, MN, MX, 32'h1);
        dir_rows[11] = mk_row(17'h1ffff, 32'h00010000, MN, 32'h00020000, 32'hffff0000,
                              32'h00008000, 32'h00004000, 32'h00002000, 32'hffff8000,
                              MX, MX, MN);
        // weight zero: neighbour only, extremes on the owner side ignored
        dir_rows[12] = mk_row(17'd0, MX, MX, MX, MX, MX, MX, MN, MX, 32'h00010000, 0, 0);
        dir_rows[13] = mk_row(17'd0, MN, MN, MN, MN, MN, MN, MX, MN, 0, 32'h00010000, 0);
        dir_rows[14] = mk_row(17'd0, MX, 32'h00008000, 32'h00010000, 32'h00020000,
                              32'hfffd0000, MN, MN, MN, 32'h00003000, 32'h00011000,
                              32'hfff00000);
        // negative viscosity; weights of one half, near zero and near one
        dir_rows[15] = mk_row(17'd32768, 0, 0, 0, 0, 0, 32'h00020000, 32'h00010000,
                              32'hffff0000, 32'h00004000, 32'h00006000, 0);
        dir_rows[16] = mk_row(17'd1, 0, 0, 0, 0, 0, 32'hfffe0000, 32'h00030000,
                              32'h00001000, 32'h00010000, 0, 32'h00020000);
        dir_rows[17] = mk_row(17'd65535, 32'hfff80000, 32'hfffe0000, 32'h00050000,
                              32'hfffc0000, 32'h00030000, 32'h00010000, 0,
                              32'h00002000, 0, 32'hffff0000, 0);
    end

    // random operand: full range, modest, or an extreme
    function automatic logic [31:0] rand_q(bit modest);
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff - $urandom_range(0, 1);
            1:       return 32'h80000000 + $urandom_range(0, 1);
            2, 3:    return $urandom();
            default: return modest ? 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000)
                                   : $urandom();
        endcase
    endfunction

    function automatic face_row_t rand_row();
        face_row_t r;
        bit        modest;
        modest = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 7))
            0:       r.w = 17'd65536;                            // uncoupled boundary
            1:       r.w = 17'd0;
            2:       r.w = 17'($urandom_range(65537, 131071));   // clamped
            default: r.w = 17'($urandom_range(0, 65536));
        endcase
        r.vo = rand_q(modest); r.vn = rand_q(modest);
        r.ax = rand_q(modest); r.ay = rand_q(modest); r.az = rand_q(modest);
        for (int j = 0; j < 3; j++) begin
            r.own[j] = rand_q(modest);
            r.nbr[j] = rand_q(modest);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one row per transfer, gaps in random bursts
    // ---------------------------------------------------------------
    initial begin
        face_row_t r;
        flux_t     f;
        bit        gaps_on;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        gaps_on = 1'b1;
        for (int k = 0; k < N_ITEMS; k++) begin
            r = (k < N_DIR) ? dir_rows[k] : rand_row();
            if (k % 60 == 0) gaps_on = $urandom_range(0, 2) != 0;
            if (k == QUIET_AT) quiet = 1'b1;
            if (k == PAUSE_AT) begin
                // let the block drain completely before carrying on
                s_valid <= 1'b0;
                while (flux_q.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end else if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            s_valid      <= 1'b1;
            s_weight     <= r.w;
            s_visc_own   <= r.vo;
            s_visc_nbr   <= r.vn;
            s_area_x     <= r.ax;
            s_area_y     <= r.ay;
            s_area_z     <= r.az;
            s_own_row_c0 <= r.own[0];
            s_own_row_c1 <= r.own[1];
            s_own_row_c2 <= r.own[2];
            s_nbr_row_c0 <= r.nbr[0];
            s_nbr_row_c1 <= r.nbr[1];
            s_nbr_row_c2 <= r.nbr[2];
            do @(posedge aclk); while (!s_ready);
            n_sent++;
            if (face_predict(r, f))
                flux_q.push_back((k < N_DIR && dir_has_flux[k]) ? dir_flux[k] : f);
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // Receiver: stalls in bursts, plus one long hold-off so the block backs up
    // ---------------------------------------------------------------
    initial begin
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (1500) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker and watchdog
    // ---------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        flux_t want;
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (flux_q.size() == 0) begin
                report("flux_x with nothing outstanding", 32'h0, m_flux_x);
            end else begin
                want = flux_q.pop_front();
                if (m_flux_x !== want.fx) report("flux_x", want.fx, m_flux_x);
                if (m_flux_y !== want.fy) report("flux_y", want.fy, m_flux_y);
                if (m_flux_z !== want.fz) report("flux_z", want.fz, m_flux_z);
                if (m_saturated !== want.sat)
                    report("saturated", {31'b0, want.sat}, {31'b0, m_saturated});
                if (want.sat) n_clipped++;
                n_faces++;
            end
        end
    end

    // end of run: drain, allow the latency of a closing row, then judge
    initial begin
        wait (stim_done);
        while (flux_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("covered %0d row transfers, %0d faces checked (%0d clipped)",
                 n_sent, n_faces, n_clipped);
        $display("weights 0, 1.0 and above 1.0, extreme operands, long output stall");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/vff_pkg.sv
rtl/vff_ctrl.sv
rtl/vff_dp.sv
rtl/viscous_face_flux.sv
sim/tb_top.sv
